>>> sv/mcc_pkg.sv
package mcc_pkg;

  localparam int MSEC_W    = 10;
  localparam int SEC_W     = 6;
  localparam int MIN_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int WDAY_W    = 3;
  localparam int DATE_W    = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 16;
  localparam int DRIFT_W   = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [MSEC_W:0]  MSEC_MAX  = 11'd999;
  localparam logic [SEC_W:0]   SEC_MAX   = 7'd59;
  localparam logic [MIN_W:0]   MIN_MAX   = 7'd59;
  localparam logic [HOUR_W:0]  HOUR_MAX  = 6'd23;
  localparam logic [WDAY_W:0]  WDAY_MAX  = 4'd7;
  localparam logic [MONTH_W:0] MONTH_MAX = 5'd12;

  localparam logic [DRIFT_W-1:0] PERIOD_RESET = 16'd14975;

  // 25 * INV25 == 1 mod 2^16; y divisible by 25 iff y * INV25 mod 2^16 <= 65535 / 25
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  localparam logic [APB_AW-1:0] REG_CORR_PERIOD = 3'd0;

  typedef struct packed {
    logic [MSEC_W-1:0]  msec;
    logic [SEC_W-1:0]   sec;
    logic [MIN_W-1:0]   min;
    logic [HOUR_W-1:0]  hour;
    logic [WDAY_W-1:0]  weekday;
    logic [DATE_W-1:0]  date;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_time_t;

  localparam cal_time_t TIME_RESET = '{
    msec: '0, sec: '0, min: '0, hour: '0,
    weekday: 3'd1, date: 5'd1, month: 4'd1, year: '0
  };

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DATE_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DATE_W-1:0] d;
    case (m)
      MONTH_FEB: d = leap ? 5'd29 : 5'd28;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: d = 5'd30;
      default:   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> sv/millisecond_calendar_clock_core.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_func, in_set_msec .. in_set_year
// out_    | output    | out_valid/out_stall | out_now_msec .. out_now_year
// APB     | input     | psel/penable/pready | paddr, pwdata, prdata (correction_period at 0)
//
// One word per cycle while in_stall is low; each accepted word shows its time in the next cycle.
// The time registers feed the outputs directly; the next time is one pass of
// the carry chain plus a 16x16 constant multiply for the leap test.
// Reset (rst_n low, synchronous) gives 00:00:00.000, weekday 1, 1/1/0.
// in_stall is high only while a result waits and out_stall is high.
module millisecond_calendar_clock_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [9:0]                  in_set_msec,
  input  logic [5:0]                  in_set_sec,
  input  logic [5:0]                  in_set_min,
  input  logic [4:0]                  in_set_hour,
  input  logic [2:0]                  in_set_weekday,
  input  logic [4:0]                  in_set_date,
  input  logic [3:0]                  in_set_month,
  input  logic [15:0]                 in_set_year,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [9:0]                  out_now_msec,
  output logic [5:0]                  out_now_sec,
  output logic [5:0]                  out_now_min,
  output logic [4:0]                  out_now_hour,
  output logic [2:0]                  out_now_weekday,
  output logic [4:0]                  out_now_date,
  output logic [3:0]                  out_now_month,
  output logic [15:0]                 out_now_year,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcc_pkg::APB_AW-1:0]  paddr,
  input  logic [mcc_pkg::APB_DW-1:0]  pwdata,
  output logic [mcc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import mcc_pkg::*;

  cal_time_t           time_r, time_nxt, tick_time, load_time;
  logic [DRIFT_W-1:0]  drift_r, drift_nxt, drift_inc;
  logic [DRIFT_W-1:0]  period_r;
  logic                out_valid_r, out_valid_nxt;
  logic                in_accept;

  mcc_advance u_advance (
    .cur (time_r),
    .nxt (tick_time)
  );

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_CORR_PERIOD) ? APB_DW'(period_r) : '0;

  always_comb begin
    load_time = '{
      msec: in_set_msec, sec: in_set_sec, min: in_set_min, hour: in_set_hour,
      weekday: in_set_weekday, date: in_set_date, month: in_set_month,
      year: in_set_year
    };
    drift_inc     = drift_r + 1'b1;
    time_nxt      = time_r;
    drift_nxt     = drift_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      if (in_func) begin
        time_nxt = load_time;
      end else if (drift_inc == period_r) begin
        // drop this tick
        drift_nxt = '0;
      end else begin
        drift_nxt = drift_inc;
        time_nxt  = tick_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= TIME_RESET;
      drift_r     <= '0;
      period_r    <= PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      time_r      <= time_nxt;
      drift_r     <= drift_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && (paddr == REG_CORR_PERIOD)) begin
        period_r <= pwdata[DRIFT_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_now_msec    = time_r.msec;
  assign out_now_sec     = time_r.sec;
  assign out_now_min     = time_r.min;
  assign out_now_hour    = time_r.hour;
  assign out_now_weekday = time_r.weekday;
  assign out_now_date    = time_r.date;
  assign out_now_month   = time_r.month;
  assign out_now_year    = time_r.year;

endmodule

>>> sv/mcc_advance.sv
module mcc_advance (
  input  mcc_pkg::cal_time_t cur,
  output mcc_pkg::cal_time_t nxt
);
  import mcc_pkg::*;

  logic [MSEC_W:0]  msec_inc;
  logic [SEC_W:0]   sec_inc;
  logic [MIN_W:0]   min_inc;
  logic [HOUR_W:0]  hour_inc;
  logic [WDAY_W:0]  wday_inc;
  logic [DATE_W:0]  date_inc;
  logic [MONTH_W:0] month_inc;
  logic [DATE_W-1:0] dim;
  logic msec_wrap, sec_wrap, min_wrap, hour_wrap, date_wrap, month_wrap;

  always_comb begin
    msec_inc  = {1'b0, cur.msec} + 1'b1;
    sec_inc   = {1'b0, cur.sec} + 1'b1;
    min_inc   = {1'b0, cur.min} + 1'b1;
    hour_inc  = {1'b0, cur.hour} + 1'b1;
    wday_inc  = {1'b0, cur.weekday} + 1'b1;
    date_inc  = {1'b0, cur.date} + 1'b1;
    month_inc = {1'b0, cur.month} + 1'b1;
    dim       = month_days(cur.month, is_leap(cur.year));

    msec_wrap  = msec_inc > MSEC_MAX;
    sec_wrap   = msec_wrap && (sec_inc > SEC_MAX);
    min_wrap   = sec_wrap && (min_inc > MIN_MAX);
    hour_wrap  = min_wrap && (hour_inc > HOUR_MAX);
    date_wrap  = hour_wrap && (date_inc > {1'b0, dim});
    month_wrap = date_wrap && (month_inc > MONTH_MAX);

    nxt = cur;
    nxt.msec = msec_wrap ? '0 : msec_inc[MSEC_W-1:0];
    if (msec_wrap) begin
      nxt.sec = sec_wrap ? '0 : sec_inc[SEC_W-1:0];
    end
    if (sec_wrap) begin
      nxt.min = min_wrap ? '0 : min_inc[MIN_W-1:0];
    end
    if (min_wrap) begin
      nxt.hour = hour_wrap ? '0 : hour_inc[HOUR_W-1:0];
    end
    if (hour_wrap) begin
      nxt.weekday = (wday_inc > WDAY_MAX) ? WDAY_W'(1) : wday_inc[WDAY_W-1:0];
      nxt.date    = date_wrap ? DATE_W'(1) : date_inc[DATE_W-1:0];
    end
    if (date_wrap) begin
      nxt.month = month_wrap ? MONTH_W'(1) : month_inc[MONTH_W-1:0];
    end
    if (month_wrap) begin
      nxt.year = cur.year + 1'b1;
    end
  end

endmodule

>>> sv/mcc_checker.sv
module mcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic [9:0]  in_set_msec,
  input logic [15:0] in_set_year,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_now_msec,
  input logic [15:0] out_now_year
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word shows no result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=>
      out_now_msec == $past(in_set_msec) && out_now_year == $past(in_set_year))
    else $error("loaded time not shown");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_now_msec) && $stable(out_now_year))
    else $error("stalled result changed");

endmodule

bind millisecond_calendar_clock_core mcc_checker u_mcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_func      (in_func),
  .in_set_msec  (in_set_msec),
  .in_set_year  (in_set_year),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_now_msec (out_now_msec),
  .out_now_year (out_now_year)
);

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 30;
  localparam int PHASE_WORDS    = 130;
  localparam int DRIFT_TICKS    = 30;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_func = 1'b0;
  logic [9:0]        in_set_msec = '0;
  logic [5:0]        in_set_sec = '0;
  logic [5:0]        in_set_min = '0;
  logic [4:0]        in_set_hour = '0;
  logic [2:0]        in_set_weekday = '0;
  logic [4:0]        in_set_date = '0;
  logic [3:0]        in_set_month = '0;
  logic [15:0]       in_set_year = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [9:0]        out_now_msec;
  logic [5:0]        out_now_sec;
  logic [5:0]        out_now_min;
  logic [4:0]        out_now_hour;
  logic [2:0]        out_now_weekday;
  logic [4:0]        out_now_date;
  logic [3:0]        out_now_month;
  logic [15:0]       out_now_year;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cal_time_t   clock_now;
  logic [15:0] drift_ticks;
  logic [15:0] drop_period;
  cal_time_t   expected_times[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  millisecond_calendar_clock_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_set_msec     (in_set_msec),
    .in_set_sec      (in_set_sec),
    .in_set_min      (in_set_min),
    .in_set_hour     (in_set_hour),
    .in_set_weekday  (in_set_weekday),
    .in_set_date     (in_set_date),
    .in_set_month    (in_set_month),
    .in_set_year     (in_set_year),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_now_msec    (out_now_msec),
    .out_now_sec     (out_now_sec),
    .out_now_min     (out_now_min),
    .out_now_hour    (out_now_hour),
    .out_now_weekday (out_now_weekday),
    .out_now_date    (out_now_date),
    .out_now_month   (out_now_month),
    .out_now_year    (out_now_year),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  function automatic bit gregorian_leap(logic [15:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(logic [3:0] m, logic [15:0] y);
    if (m < 1 || m > 12) return 31;
    if (m == 2) return gregorian_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic void advance_one_ms();
    if (clock_now.msec < 999) begin
      clock_now.msec++;
    end else begin
      clock_now.msec = '0;
      if (clock_now.sec < 59) begin
        clock_now.sec++;
      end else begin
        clock_now.sec = '0;
        if (clock_now.min < 59) begin
          clock_now.min++;
        end else begin
          clock_now.min = '0;
          if (clock_now.hour < 23) begin
            clock_now.hour++;
          end else begin
            clock_now.hour = '0;
            clock_now.weekday = (clock_now.weekday < 7) ? clock_now.weekday + 3'd1 : 3'd1;
            if (clock_now.date < month_length(clock_now.month, clock_now.year)) begin
              clock_now.date++;
            end else begin
              clock_now.date = 5'd1;
              if (clock_now.month < 12) begin
                clock_now.month++;
              end else begin
                clock_now.month = 4'd1;
                clock_now.year++;
              end
            end
          end
        end
      end
    end
  endfunction

  function automatic cal_time_t clock_step(bit func, cal_time_t set);
    if (func) begin
      clock_now = set;
    end else begin
      drift_ticks = drift_ticks + 16'd1;
      if (drift_ticks == drop_period) drift_ticks = '0;
      else advance_one_ms();
    end
    return clock_now;
  endfunction

  function automatic cal_time_t make_time(int ms, int s, int mi, int h, int wd, int d, int mo,
                                          int y);
    cal_time_t t;
    t.msec    = 10'(ms);
    t.sec     = 6'(s);
    t.min     = 6'(mi);
    t.hour    = 5'(h);
    t.weekday = 3'(wd);
    t.date    = 5'(d);
    t.month   = 4'(mo);
    t.year    = 16'(y);
    return t;
  endfunction

  function automatic cal_time_t random_fields();
    return make_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
  endfunction

  function automatic cal_time_t near_rollover();
    cal_time_t t;
    int        len;
    case ($urandom_range(0, 5))
      0:       t.year = 16'($urandom_range(0, 163) * 400);
      1:       t.year = 16'($urandom_range(0, 655) * 100);
      2:       t.year = 16'($urandom_range(0, 16383) * 4);
      3:       t.year = 16'hFFFF;
      default: t.year = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    t.month = 4'd2;
      2:       t.month = 4'd12;
      3:       t.month = 4'($urandom_range(0, 15));
      default: t.month = 4'($urandom_range(1, 12));
    endcase
    len = month_length(t.month, t.year);
    case ($urandom_range(0, 5))
      0:       t.date = 5'($urandom_range(0, 31));
      1:       t.date = 5'(len - 1);
      default: t.date = 5'(len);
    endcase
    case ($urandom_range(0, 9))
      0:       t.msec = 10'($urandom_range(0, 1023));
      1, 2:    t.msec = 10'($urandom_range(0, 999));
      default: t.msec = 10'(999 - $urandom_range(0, 8));
    endcase
    t.sec     = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'd59;
    t.min     = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'd59;
    t.hour    = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'd23;
    t.weekday = 3'($urandom_range(0, 7));
    return t;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  task automatic drive_word(input bit func, input cal_time_t set);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 25);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_func        <= func;
    in_set_msec    <= set.msec;
    in_set_sec     <= set.sec;
    in_set_min     <= set.min;
    in_set_hour    <= set.hour;
    in_set_weekday <= set.weekday;
    in_set_date    <= set.date;
    in_set_month   <= set.month;
    in_set_year    <= set.year;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_times.push_back(clock_step(func, set));
  endtask

  task automatic tick(input int count);
    repeat (count) drive_word(1'b0, random_fields());
  endtask

  task automatic load_time(input cal_time_t t);
    drive_word(1'b1, t);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write_period(input logic [15:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CORR_PERIOD;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    drop_period = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field("correction_period", value, prdata[15:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_state();
    tick(1);
  endtask

  task automatic test_load_extremes();
    load_time(make_time(999, 59, 59, 23, 7, 31, 12, 65535));
    tick(1);
    load_time(make_time(0, 0, 0, 0, 0, 0, 0, 0));
    tick(1);
    load_time(make_time(1023, 63, 63, 31, 7, 31, 15, 65535));
    tick(1);
  endtask

  task automatic test_month_ends();
    load_time(make_time(999, 59, 59, 23, 3, 28, 2, 2023));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 4, 28, 2, 2024));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 5, 28, 2, 1900));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 6, 28, 2, 2000));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 7, 30, 4, 2021));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 1, 30, 0, 5));
    tick(1);
    load_time(make_time(999, 59, 59, 23, 2, 31, 13, 7));
    tick(1);
  endtask

  task automatic test_drift_drop();
    cfg_write_period(16'd3);
    tick(1);
    load_time(near_rollover());
    tick(3);
    cfg_write_period(16'd1);
    tick(2);
  endtask

  task automatic test_period_zero();
    cfg_write_period(16'd0);
    tick(DRIFT_TICKS);
  endtask

  task automatic test_drift_above_period();
    cfg_write_period(16'd20);
    tick(15);
    cfg_write_period(16'd5);
    tick(DRIFT_TICKS);
  endtask

  task automatic random_traffic(input int words);
    int sent;
    int n;
    sent = 0;
    while (sent < words) begin
      case ($urandom_range(0, 9))
        0: begin
          load_time(random_fields());
          n = $urandom_range(0, 3);
        end
        1: n = $urandom_range(1, 20);
        default: begin
          load_time(near_rollover());
          n = $urandom_range(1, 12);
        end
      endcase
      tick(n);
      sent += n + 1;
    end
  endtask

  task automatic test_random_periods();
    cfg_write_period(16'd1);
    random_traffic(PHASE_WORDS);
    cfg_write_period(16'd2);
    random_traffic(PHASE_WORDS);
    cfg_write_period(16'($urandom_range(3, 40)));
    random_traffic(PHASE_WORDS);
    cfg_write_period(16'd65535);
    random_traffic(PHASE_WORDS);
    cfg_write_period(16'($urandom_range(1, 65535)));
    random_traffic(PHASE_WORDS);
    cfg_write_period(16'($urandom_range(2, 12)));
    random_traffic(PHASE_WORDS);
  endtask

  // receiver: hold off results in stretches of varying density
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 6) : $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cal_time_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_times.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $error("time word arrived with none pending");
      end else begin
        want = expected_times.pop_front();
        check_field("now_msec", want.msec, out_now_msec);
        check_field("now_sec", want.sec, out_now_sec);
        check_field("now_min", want.min, out_now_min);
        check_field("now_hour", want.hour, out_now_hour);
        check_field("now_weekday", want.weekday, out_now_weekday);
        check_field("now_date", want.date, out_now_date);
        check_field("now_month", want.month, out_now_month);
        check_field("now_year", want.year, out_now_year);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    clock_now   = make_time(0, 0, 0, 0, 1, 1, 1, 0);
    drift_ticks = '0;
    drop_period = 16'd14975;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_load_extremes();
    test_month_ends();
    test_drift_drop();
    test_period_zero();
    test_drift_above_period();
    test_random_periods();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_times.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mcc_pkg.sv
sv/mcc_advance.sv
sv/millisecond_calendar_clock_core.sv
sv/mcc_checker.sv
test/testbench.sv
